>>> hdl/multichannel_input_change_reporter_defines.svh
// assertion macros for the input change reporter
// no dependencies; taken in by the files that carry assertions
`ifndef MULTICHANNEL_INPUT_CHANGE_REPORTER_DEFINES_SVH
`define MULTICHANNEL_INPUT_CHANGE_REPORTER_DEFINES_SVH

`ifndef SYNTH
// checked on every rising clock edge, quiet while reset is high
`define MICR_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every rising clock edge, reset included
`define MICR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MICR_ASSERT_RST(name, clk, rst, prop, msg)
`define MICR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> hdl/micr_pkg.sv
// types and constants of the multichannel input change reporter
// no dependencies; used by the top level
package micr_pkg;

   localparam int CHANNEL_W = 6;
   localparam int VALUE_W   = 10;
   localparam int COUNT_W   = 5;   // counter never exceeds the largest 5-bit filter count
   localparam int FILTER_W  = 5;
   localparam int THRESH_W  = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [FILTER_W-1:0] FILTER_RESET = 5'd16;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_COUNT     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANALOG_THRESHOLD = 1'b1;

   // channel kinds
   localparam logic KIND_DIGITAL = 1'b0;
   localparam logic KIND_ANALOG  = 1'b1;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [VALUE_W-1:0]   value;
   } report_type;

endpackage

>>> hdl/micr_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; holds the per-channel state of the reporter
module micr_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/multichannel_input_change_reporter.sv
// a reported request passes from accept through the update stage into the result queue, then shows on rsp_valid
// throughput: one request per cycle while the result queue has room; the channel ram is read at accept
// and written back from the update stage in the cycle after, a same-channel request next cycle is forwarded
// reset: synchronous; per-channel flags mark all state as zero at once, no clearing pass
// top level of the multichannel input change reporter; uses micr_pkg and micr_ram
module multichannel_input_change_reporter
   import micr_pkg::*;
#(
   parameter int CHANNELS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic                  req_kind,
   input  logic [VALUE_W-1:0]    req_sample,
   input  logic                  req_force_report,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [CHANNEL_W-1:0]  rsp_report_channel,
   output logic [VALUE_W-1:0]    rsp_report_value,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "multichannel_input_change_reporter_defines.svh"

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // configuration
   logic [FILTER_W-1:0] filter_ff;
   logic [THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= FILTER_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FILTER_COUNT:     filter_ff <= csr_wdata[FILTER_W-1:0];
            CSR_ANALOG_THRESHOLD: thresh_ff <= csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // request side
   logic             acc;
   logic             take;
   logic             in_range;
   logic [IDX_W-1:0] ch_idx;

   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;
   logic                  s1_valid_ff;

   assign in_range  = {3'b000, req_channel} < 9'(CHANNELS);
   assign ch_idx    = IDX_W'(req_channel);
   assign req_ready = (fifo_cnt_ff + FIFO_CNT_W'(s1_valid_ff)) <= FIFO_CNT_W'(FIFO_DEPTH - 1);
   assign acc       = req_valid && req_ready;
   assign take      = acc && in_range;

   // channel state memory
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [$bits(entry_type)-1:0] ram_q;

   micr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (take),
      .rd_addr (ch_idx),
      .rd_data (ram_q)
   );

   // an entry never written since reset reads as zero
   logic [CHANNELS-1:0] written_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // update stage
   logic [IDX_W-1:0]     s1_addr_ff;
   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic                 s1_kind_ff;
   logic [VALUE_W-1:0]   s1_sample_ff;
   logic                 s1_force_ff;
   logic                 s1_written_ff;
   logic                 fwd_hit_ff;
   entry_type            fwd_data_ff;
   logic                 fwd_hit_in;

   assign fwd_hit_in = wr_en && (wr_addr == ch_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_addr_ff    <= ch_idx;
         s1_channel_ff <= req_channel;
         s1_kind_ff    <= req_kind;
         s1_sample_ff  <= req_sample;
         s1_force_ff   <= req_force_report;
         s1_written_ff <= written_ff[ch_idx];
         fwd_hit_ff    <= fwd_hit_in;
         fwd_data_ff   <= wr_data;
      end
   end

   entry_type          cur;
   logic [VALUE_W-1:0] delta;
   logic               report;
   entry_type          nxt;

   always_comb begin
      // write of the previous request to this channel lands at the read edge
      if (fwd_hit_ff) begin
         cur = fwd_data_ff;
      end else if (s1_written_ff) begin
         cur = entry_type'(ram_q);
      end else begin
         cur = '0;
      end
   end

   assign delta = (s1_sample_ff >= cur.value) ? (s1_sample_ff - cur.value)
                                              : (cur.value - s1_sample_ff);

   always_comb begin
      report    = 1'b0;
      nxt.value = cur.value;
      nxt.count = cur.count;
      if (s1_force_ff) begin
         report = 1'b1;
      end else if (s1_kind_ff == KIND_ANALOG) begin
         report = delta >= {3'b000, thresh_ff};
      end else if (s1_sample_ff == cur.value) begin
         nxt.count = '0;
      end else if (cur.count < filter_ff) begin
         nxt.count = cur.count + COUNT_W'(1);
      end else begin
         report = 1'b1;
      end
      if (report) begin
         nxt.value = s1_sample_ff;
         nxt.count = '0;
      end
   end

   assign wr_en   = s1_valid_ff;
   assign wr_addr = s1_addr_ff;
   assign wr_data = nxt;

   // result queue
   report_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic                  push;
   logic                  pop;

   assign push = s1_valid_ff && report;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{channel: s1_channel_ff, value: s1_sample_ff};
      end
   end

   assign rsp_valid          = fifo_cnt_ff != '0;
   assign rsp_report_channel = fifo_ff[rd_ptr_ff].channel;
   assign rsp_report_value   = fifo_ff[rd_ptr_ff].value;

   // checks
   `MICR_ASSERT_RST(a_fifo_bound, clock, reset,
      fifo_cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH), "result queue over depth")
   `MICR_ASSERT_RST(a_push_room, clock, reset,
      push |-> (fifo_cnt_ff < FIFO_CNT_W'(FIFO_DEPTH)), "report pushed into a full queue")
   `MICR_ASSERT_RST(a_take_update, clock, reset,
      take |=> s1_valid_ff, "accepted request missing from update stage")
   `MICR_ASSERT_RST(a_fwd_addr, clock, reset,
      (s1_valid_ff && fwd_hit_ff) |-> ($past(wr_addr) == s1_addr_ff),
      "forwarded entry from another channel")

endmodule
